### rtl/pelc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_pkg: shared types and constants
// Status codes, command kinds and the command record passed front to back.
// ----------------------------------------------------------------------------
package pelc_pkg;

	localparam int PELC_PINS      = 32;
	localparam int PELC_LOG_DEPTH = 8;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_INVALID   = 2'd1,
		STAT_UNCLAIMED = 2'd2,
		STAT_TIMEOUT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_RESP = 2'd0,   // answer already known, no log access
		CMD_PUSH = 2'd1,
		CMD_MEAS = 2'd2
	} cmd_kind_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_MEAS = 1'b1
	} req_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		status_t     status;
		logic [7:0]  pin;
		logic        level;
		logic [63:0] tstamp;   // edge time for push, now for measure
		logic [31:0] timeout;
	} cmd_t;

endpackage

### rtl/pelc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_req_if / pelc_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface pelc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  pin;
	logic        level;
	logic [63:0] now_us;
	logic [63:0] offset_us;
	logic [31:0] limit_us;
	logic        pin_claimed;

	modport source (output valid, req_type, pin, level, now_us, offset_us, limit_us,
		pin_claimed, input ready);
	modport sink (input valid, req_type, pin, level, now_us, offset_us, limit_us,
		pin_claimed, output ready);
endinterface

interface pelc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] pulse_width;
	logic [63:0] clock_advance_us;

	modport source (output valid, status, pulse_width, clock_advance_us, input ready);
	modport sink (input valid, status, pulse_width, clock_advance_us, output ready);
endinterface

### rtl/pelc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_fifo: two-entry command queue
// Decouples request intake from log processing.
// ----------------------------------------------------------------------------
module pelc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pelc_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output pelc_pkg::cmd_t rd_cmd,
	output logic           not_empty
);
	import pelc_pkg::*;

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign rd_cmd    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

### rtl/pelc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_front: request intake and classification
// Range and claim checks, edge-time add, command build.
// ----------------------------------------------------------------------------
module pelc_front #(
	parameter int PINS = pelc_pkg::PELC_PINS
) (
	pelc_req_if.sink         req,
	input  logic             q_full,
	output logic             q_wr,
	output pelc_pkg::cmd_t   q_cmd
);
	import pelc_pkg::*;

	logic pin_ok;

	assign pin_ok   = ({1'b0, req.pin} < 9'(PINS));
	assign req.ready = !q_full;
	assign q_wr      = req.valid && !q_full;

	always_comb begin
		q_cmd.pin     = req.pin;
		q_cmd.level   = req.level;
		q_cmd.timeout = req.limit_us;
		q_cmd.status  = STAT_OK;
		q_cmd.kind    = CMD_RESP;
		q_cmd.tstamp  = req.now_us;
		if (!pin_ok) begin
			q_cmd.status = STAT_INVALID;
		end else if (req.req_type == REQ_PUSH) begin
			q_cmd.kind   = CMD_PUSH;
			q_cmd.tstamp = req.now_us + req.offset_us;
		end else if (!req.pin_claimed) begin
			q_cmd.status = STAT_UNCLAIMED;
		end else begin
			q_cmd.kind = CMD_MEAS;
		end
	end
endmodule

### rtl/pelc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_back: edge log engine
// Circular per-pin logs in one memory; push, measure scan, response register.
// ----------------------------------------------------------------------------
module pelc_back #(
	parameter int PINS      = pelc_pkg::PELC_PINS,
	parameter int LOG_DEPTH = pelc_pkg::PELC_LOG_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pelc_pkg::cmd_t q_cmd,
	output logic           q_rd,
	pelc_rsp_if.source     rsp
);
	import pelc_pkg::*;

	localparam int PW      = (PINS > 1) ? $clog2(PINS) : 1;
	localparam int SW      = $clog2(LOG_DEPTH);
	localparam int CW      = $clog2(LOG_DEPTH + 1);
	localparam int ENTRIES = PINS * LOG_DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PUSH  = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_CHK   = 7'b0001000,
		ST_FIN_A = 7'b0010000,
		ST_FIN_B = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_q  [PINS];
	logic [SW-1:0] head_q [PINS];
	logic [64:0]   mem    [ENTRIES];   // {level, time}
	logic [64:0]   rdata_q;
	logic [CW-1:0] idx_q;
	logic          have_start_q;
	logic          have_end_q;
	logic          ok_q;
	logic [63:0]   t0_q;
	logic [63:0]   t1_q;
	logic [31:0]   width_q;
	logic [63:0]   adv_q;
	status_t       stat_q;
	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [31:0]   rsp_width_q;
	logic [63:0]   rsp_adv_q;

	logic [PW-1:0] pin_i;
	logic [CW-1:0] cnt_i;
	logic [SW-1:0] head_i;
	logic [CW:0]   lsum;
	logic [SW-1:0] slot;
	logic [AW-1:0] addr;
	logic          full_log;
	logic [CW-1:0] nidx;
	logic          out_free;

	assign pin_i    = cmd_q.pin[PW-1:0];
	assign cnt_i    = cnt_q[pin_i];
	assign head_i   = head_q[pin_i];
	assign full_log = (cnt_i == CW'(LOG_DEPTH));
	assign nidx     = idx_q + CW'(1);
	assign out_free = !rsp_valid_q || rsp.ready;

	// logical position -> physical slot, wrap once
	always_comb begin
		if (state_q == ST_PUSH) begin
			lsum = full_log ? (CW+1)'(head_i) : (CW+1)'(head_i) + (CW+1)'(cnt_i);
		end else begin
			lsum = (CW+1)'(head_i) + (CW+1)'(idx_q);
		end
		if (lsum >= (CW+1)'(LOG_DEPTH)) begin
			slot = SW'(lsum - (CW+1)'(LOG_DEPTH));
		end else begin
			slot = SW'(lsum);
		end
		addr = AW'(AW'(pin_i) * AW'(LOG_DEPTH) + AW'(slot));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH) begin
			mem[addr] <= {cmd_q.level, cmd_q.tstamp};
		end
		if (state_q == ST_RD) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			for (int p = 0; p < PINS; p++) begin
				cnt_q[p]  <= '0;
				head_q[p] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q        <= q_cmd;
						idx_q        <= '0;
						have_start_q <= 1'b0;
						have_end_q   <= 1'b0;
						stat_q       <= q_cmd.status;
						width_q      <= '0;
						adv_q        <= '0;
						case (q_cmd.kind)
							CMD_PUSH: state_q <= ST_PUSH;
							CMD_MEAS: begin
								if (cnt_q[q_cmd.pin[PW-1:0]] == '0) begin
									state_q <= ST_FIN_A;
								end else begin
									state_q <= ST_RD;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PUSH: begin
					if (full_log) begin
						head_q[pin_i] <= (head_i == SW'(LOG_DEPTH - 1)) ? '0 : head_i + SW'(1);
					end else begin
						cnt_q[pin_i] <= cnt_i + CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					idx_q <= nidx;
					if (!have_start_q && rdata_q[64] == cmd_q.level) begin
						have_start_q <= 1'b1;
						t0_q         <= rdata_q[63:0];
						state_q      <= (nidx == cnt_i) ? ST_FIN_A : ST_RD;
					end else if (have_start_q && rdata_q[64] != cmd_q.level) begin
						have_end_q <= 1'b1;
						t1_q       <= rdata_q[63:0];
						state_q    <= ST_FIN_A;
					end else begin
						state_q <= (nidx == cnt_i) ? ST_FIN_A : ST_RD;
					end
				end
				ST_FIN_A: begin
					ok_q          <= have_end_q && (t1_q > t0_q);
					width_q       <= t1_q[31:0] - t0_q[31:0];
					cnt_q[pin_i]  <= '0;
					head_q[pin_i] <= '0;
					state_q       <= ST_FIN_B;
				end
				ST_FIN_B: begin
					if (ok_q) begin
						stat_q <= STAT_OK;
						adv_q  <= (t1_q > cmd_q.tstamp) ? t1_q - cmd_q.tstamp : '0;
					end else begin
						stat_q  <= STAT_TIMEOUT;
						width_q <= '0;
						adv_q   <= 64'(cmd_q.timeout);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_status_q <= stat_q;
						rsp_width_q  <= width_q;
						rsp_adv_q    <= adv_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign q_rd                 = (state_q == ST_IDLE) && q_valid;
	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.pulse_width      = rsp_width_q;
	assign rsp.clock_advance_us = rsp_adv_q;
endmodule

### rtl/pin_edge_log_pulse_capture_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pin_edge_log_pulse_capture_unit: per-pin edge log with pulse capture
// Request channel in, one response per request out.
// Usage:
//   req: push (req_type 0) logs level at now_us + offset_us for the pin;
//        measure (req_type 1) scans the pin log for a pulse and clears it.
//   rsp: status, pulse_width, clock_advance_us, one per request, in order.
// The log memory has one port, read with a registered output, so each scanned
//   entry takes a read state (ST_RD) and a check state (ST_CHK). The engine
//   handles one request at a time.
// A two-entry queue sits behind the request port, so requests keep being
//   accepted while the engine works or the response waits, until it is full.
// Reset: all logs empty, no response pending; no clearing pass is needed.
// Receiver stall: the response register holds; the engine then stops at its
//   final step and the queue fills, after which req.ready drops.
// ----------------------------------------------------------------------------
module pin_edge_log_pulse_capture_unit #(
	parameter int PINS      = pelc_pkg::PELC_PINS,
	parameter int LOG_DEPTH = pelc_pkg::PELC_LOG_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pelc_req_if.sink   req,
	pelc_rsp_if.source rsp
);
	import pelc_pkg::*;

	cmd_t wr_cmd;
	cmd_t rd_cmd;
	logic wr_en;
	logic rd_en;
	logic full;
	logic not_empty;

	pelc_front #(.PINS(PINS)) u_front (
		.req    (req),
		.q_full (full),
		.q_wr   (wr_en),
		.q_cmd  (wr_cmd)
	);

	pelc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_cmd    (wr_cmd),
		.full      (full),
		.rd_en     (rd_en),
		.rd_cmd    (rd_cmd),
		.not_empty (not_empty)
	);

	pelc_back #(.PINS(PINS), .LOG_DEPTH(LOG_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_cmd   (rd_cmd),
		.q_rd    (rd_en),
		.rsp     (rsp)
	);
endmodule

### rtl/pelc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelc_checker: port-level checks
// Response accounting and field rules, bound to the top level.
// ----------------------------------------------------------------------------
module pelc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [31:0] pulse_width,
	input logic [63:0] clock_advance_us
);
	import pelc_pkg::*;

	logic [3:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(req_acc) - 4'(rsp_acc);
		end
	end

	// no response without an outstanding transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 4'd0)
		else $error("response with no outstanding request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(pulse_width) && $stable(clock_advance_us))
		else $error("stalled response changed");

	a_width_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> pulse_width == 32'd0)
		else $error("pulse width on failed transaction");

	a_adv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_INVALID || status == STAT_UNCLAIMED)
			|-> clock_advance_us == 64'd0)
		else $error("clock advance on rejected transaction");
endmodule

bind pin_edge_log_pulse_capture_unit pelc_checker u_pelc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.status           (rsp.status),
	.pulse_width      (rsp.pulse_width),
	.clock_advance_us (rsp.clock_advance_us)
);

### sim/tb_pin_edge_log_pulse_capture_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pin_edge_log_pulse_capture_unit: self-checking bench for the edge log
// Drives push and measure requests with random gaps, predicts each response
// from a local copy of the per-pin logs and checks responses in order.
// ----------------------------------------------------------------------------
module tb_pin_edge_log_pulse_capture_unit;
	import pelc_pkg::*;

	localparam int NPINS = PELC_PINS;
	localparam int DEPTH = PELC_LOG_DEPTH;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  pin;
		logic        level;
		logic [63:0] now_us;
		logic [63:0] offset_us;
		logic [31:0] limit_us;
		logic        pin_claimed;
	} edge_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] pulse_width;
		logic [63:0] clock_advance_us;
	} edge_rsp_t;

	logic clk;
	logic arst_n;

	pelc_req_if req ();
	pelc_rsp_if rsp ();

	pin_edge_log_pulse_capture_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	edge_req_t pending_reqs[$];
	edge_rsp_t expected_rsps[$];

	logic [63:0] log_time[NPINS][DEPTH];
	logic        log_level[NPINS][DEPTH];
	int          log_fill[NPINS];

	int  errors;
	int  n_accepted;
	int  n_checked;
	int  n_ok_meas;
	int  n_timeout;
	bit  calm_phase;
	bit  drain_hold;
	int  rsp_hold_cnt;
	bit  feed_done;

	function automatic edge_rsp_t predict_edge_log(edge_req_t r);
		edge_rsp_t   o;
		int          p;
		int          si;
		int          ei;
		logic [63:0] t0;
		logic [63:0] t1;
		o = '{status: STAT_OK, pulse_width: '0, clock_advance_us: '0};
		p = int'(r.pin);
		if (p >= NPINS) begin
			o.status = STAT_INVALID;
			return o;
		end
		if (r.req_type == REQ_PUSH) begin
			if (log_fill[p] >= DEPTH) begin
				for (int i = 1; i < DEPTH; i++) begin
					log_time[p][i-1]  = log_time[p][i];
					log_level[p][i-1] = log_level[p][i];
				end
				log_fill[p] = DEPTH - 1;
			end
			log_time[p][log_fill[p]]  = r.now_us + r.offset_us;
			log_level[p][log_fill[p]] = r.level;
			log_fill[p]++;
			return o;
		end
		if (!r.pin_claimed) begin
			o.status = STAT_UNCLAIMED;
			return o;
		end
		si = -1;
		ei = -1;
		for (int i = 0; i < log_fill[p]; i++) begin
			if (log_level[p][i] == r.level) begin
				si = i;
				break;
			end
		end
		if (si >= 0) begin
			for (int j = si + 1; j < log_fill[p]; j++) begin
				if (log_level[p][j] != r.level) begin
					ei = j;
					break;
				end
			end
		end
		log_fill[p] = 0;
		if (si >= 0 && ei >= 0) begin
			t0 = log_time[p][si];
			t1 = log_time[p][ei];
			if (t1 > t0) begin
				o.pulse_width      = 32'(t1 - t0);
				o.clock_advance_us = (t1 > r.now_us) ? t1 - r.now_us : 64'd0;
				return o;
			end
		end
		o.status           = STAT_TIMEOUT;
		o.clock_advance_us = {32'd0, r.limit_us};
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic edge_req_t mk_req(logic rt, logic [7:0] pin, logic lvl,
			logic [63:0] now, logic [63:0] dly, logic [31:0] tmo, logic clm);
		edge_req_t r;
		r.req_type    = rt;
		r.pin         = pin;
		r.level       = lvl;
		r.now_us      = now;
		r.offset_us   = dly;
		r.limit_us    = tmo;
		r.pin_claimed = clm;
		return r;
	endfunction

	// a pulse: pushed edges of mostly alternating level, then a measure
	task automatic queue_pulse_seq(int pin, bit small_times);
		logic [63:0] base;
		logic [63:0] now;
		logic        lvl;
		int          n;
		base = small_times ? 64'($urandom_range(0, 100000)) : rand64();
		now  = base;
		lvl  = 1'($urandom_range(0, 1));
		n    = $urandom_range(1, DEPTH + 3);
		for (int i = 0; i < n; i++) begin
			pending_reqs.push_back(mk_req(REQ_PUSH, 8'(pin), (i % 2 == 0) ? lvl : ~lvl,
				now, ($urandom_range(0, 9) == 0) ? rand64() :
				64'($urandom_range(0, 5000) * (i + 1)), $urandom(),
				1'($urandom_range(0, 1))));
			if ($urandom_range(0, 3) == 0)
				lvl = ~lvl;
		end
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'(pin), 1'($urandom_range(0, 1)),
			now + 64'($urandom_range(0, 20000)), rand64(), $urandom(),
			($urandom_range(0, 9) != 0)));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// directed part, then random sequences
	initial begin
		feed_done  = 1'b0;
		drain_hold = 1'b0;
		for (int i = 0; i < NPINS; i++)
			log_fill[i] = 0;
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd0, 1'b1, '0, '0, 32'd0, 1'b1));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd0, 1'b0, '1, '1, '1, 1'b1));
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd255, 1'b1, '1, '1, '1, 1'b1));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd32, 1'b1, '1, '1, '1, 1'b1));
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd31, 1'b1, 64'd100, 64'd0, '0, 1'b0));
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd31, 1'b0, 64'd100, 64'd50, '1, 1'b0));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd31, 1'b1, 64'd100, '0, '1, 1'b0));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd31, 1'b1, 64'd120, '0, '1, 1'b1));
		// wrapped end time lies below start: timeout
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd1, 1'b0, '1, 64'd0, '0, 1'b1));
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd1, 1'b1, '1, 64'd5, '0, 1'b1));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd1, 1'b0, 64'd0, '0, 32'h1234, 1'b1));
		// overfull log drops oldest; end equals start
		for (int i = 0; i < DEPTH + 2; i++)
			pending_reqs.push_back(mk_req(REQ_PUSH, 8'd2, i[0], 64'd1000, 64'(i / 2), '0,
				1'b1));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd2, 1'b0, 64'd1000, '0, '1, 1'b1));
		// end time before now: zero advance
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd3, 1'b1, 64'h8000_0000_0000_0000,
			64'h0, '0, 1'b1));
		pending_reqs.push_back(mk_req(REQ_PUSH, 8'd3, 1'b0, 64'h8000_0000_0000_0000,
			64'h1_0000_0005, '0, 1'b1));
		pending_reqs.push_back(mk_req(REQ_MEAS, 8'd3, 1'b1, '1, '0, '0, 1'b1));

		while (pending_reqs.size() < 560) begin
			if ($urandom_range(0, 9) < 8)
				queue_pulse_seq($urandom_range(0, NPINS - 1), 1'($urandom_range(0, 1)));
			else
				pending_reqs.push_back(mk_req(1'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ? 8'($urandom_range(NPINS, 255)) :
					8'($urandom_range(0, NPINS - 1)), 1'($urandom_range(0, 1)), rand64(),
					rand64(), $urandom(), 1'($urandom_range(0, 1))));
			if (pending_reqs.size() > 200 && pending_reqs.size() < 260)
				break;
		end
		wait (pending_reqs.size() == 0);
		// pause the feed until everything has drained
		drain_hold = 1'b1;
		wait (!req.valid && expected_rsps.size() == 0 && !rsp.valid);
		drain_hold = 1'b0;
		while (pending_reqs.size() < 345)
			queue_pulse_seq($urandom_range(0, NPINS - 1), 1'($urandom_range(0, 1)));
		wait (pending_reqs.size() == 0);
		feed_done = 1'b1;
	end

	initial begin
		calm_phase = 1'b0;
		#20000;
		calm_phase = 1'b1;
		#20000;
		calm_phase = 1'b0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.req_type    <= 1'b0;
			req.pin         <= '0;
			req.level       <= 1'b0;
			req.now_us      <= '0;
			req.offset_us   <= '0;
			req.limit_us    <= '0;
			req.pin_claimed <= 1'b0;
			n_accepted      <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(predict_edge_log({req.req_type, req.pin, req.level,
					req.now_us, req.offset_us, req.limit_us, req.pin_claimed}));
				n_accepted <= n_accepted + 1;
			end
			if (!req.valid || req.ready) begin
				if (pending_reqs.size() > 0 && !drain_hold &&
						(calm_phase || $urandom_range(0, 99) >= 36)) begin
					edge_req_t r;
					r = pending_reqs.pop_front();
					req.valid       <= 1'b1;
					req.req_type    <= r.req_type;
					req.pin         <= r.pin;
					req.level       <= r.level;
					req.now_us      <= r.now_us;
					req.offset_us   <= r.offset_us;
					req.limit_us    <= r.limit_us;
					req.pin_claimed <= r.pin_claimed;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor; a long receiver hold-off early on fills the engine and its queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready    <= 1'b0;
			rsp_hold_cnt <= 0;
			errors       = 0;
			n_checked    <= 0;
			n_ok_meas    <= 0;
			n_timeout    <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				edge_rsp_t e;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response status=%0d", $realtime, rsp.status);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status) begin
						$display("%0t: status exp %0d got %0d", $realtime, e.status, rsp.status);
						errors++;
					end
					if (rsp.pulse_width !== e.pulse_width) begin
						$display("%0t: pulse_width exp %0h got %0h", $realtime, e.pulse_width,
							rsp.pulse_width);
						errors++;
					end
					if (rsp.clock_advance_us !== e.clock_advance_us) begin
						$display("%0t: clock_advance_us exp %0h got %0h", $realtime,
							e.clock_advance_us, rsp.clock_advance_us);
						errors++;
					end
					if (e.status == STAT_OK && e.clock_advance_us != 0 || e.pulse_width != 0)
						n_ok_meas <= n_ok_meas + 1;
					if (e.status == STAT_TIMEOUT)
						n_timeout <= n_timeout + 1;
				end
				n_checked <= n_checked + 1;
			end
			rsp_hold_cnt <= rsp_hold_cnt + 1;
			if (rsp_hold_cnt >= 300 && rsp_hold_cnt < 500)
				rsp.ready <= 1'b0;
			else
				rsp.ready <= calm_phase || ($urandom_range(0, 99) >= 36);
		end
	end

	initial begin
		int tail;
		wait (arst_n === 1'b1);
		wait (feed_done && !req.valid);
		wait (expected_rsps.size() == 0);
		tail = 0;
		while (tail < 100) begin
			@(posedge clk);
			tail++;
		end
		$display("Checked %0d responses of %0d requests: %0d measured pulses, %0d timeouts.",
			n_checked, n_accepted, n_ok_meas, n_timeout);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
